### hw/rtl/u8cw_pkg.sv
// ----------------------------------------------------------------------------
// u8cw_pkg
// Shared types and constants for the UTF-8 code point and width decoder.
// ----------------------------------------------------------------------------
package u8cw_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned LenW  = 3;
  localparam int unsigned WidW  = 2;

  // Sequence lengths.
  localparam logic [LenW-1:0] LEN_1 = 3'd1;
  localparam logic [LenW-1:0] LEN_2 = 3'd2;
  localparam logic [LenW-1:0] LEN_3 = 3'd3;
  localparam logic [LenW-1:0] LEN_4 = 3'd4;

  // Display width codes.
  localparam logic [WidW-1:0] WID_ZERO   = 2'd0;
  localparam logic [WidW-1:0] WID_NORMAL = 2'd1;
  localparam logic [WidW-1:0] WID_WIDE   = 2'd2;

  // Lead and continuation byte patterns.
  localparam logic [ByteW-1:0] MASK_2B = 8'hE0;
  localparam logic [ByteW-1:0] LEAD_2B = 8'hC0;
  localparam logic [ByteW-1:0] MASK_3B = 8'hF0;
  localparam logic [ByteW-1:0] LEAD_3B = 8'hE0;
  localparam logic [ByteW-1:0] MASK_4B = 8'hF8;
  localparam logic [ByteW-1:0] LEAD_4B = 8'hF0;
  localparam logic [ByteW-1:0] MASK_CONT = 8'hC0;
  localparam logic [ByteW-1:0] CONT_PAT  = 8'h80;

  // Decoded result of one item.
  typedef struct packed {
    logic [CpW-1:0]  code_point;
    logic [LenW-1:0] seq_length;
    logic            well_formed;
    logic [WidW-1:0] display_width;
  } result_t;

endpackage

### hw/rtl/u8cw_decode.sv
// ----------------------------------------------------------------------------
// u8cw_decode
// Combinational decode of one UTF-8 sequence from a four-byte window, plus
// the terminal column width of the resulting code point.
// ----------------------------------------------------------------------------
module u8cw_decode (
  input  logic [u8cw_pkg::ByteW-1:0] lead_byte,
  input  logic [u8cw_pkg::ByteW-1:0] second_byte,
  input  logic [u8cw_pkg::ByteW-1:0] third_byte,
  input  logic [u8cw_pkg::ByteW-1:0] fourth_byte,
  output u8cw_pkg::result_t          result
);

  logic                        cont1;
  logic                        cont2;
  logic                        cont3;
  logic [u8cw_pkg::CpW-1:0]    cp;
  logic [u8cw_pkg::LenW-1:0]   len;
  logic                        ok;
  logic [15:0]                 lo;
  logic                        bmp;
  logic                        is_ctrl;
  logic                        is_wide;

  // Continuation byte checks.
  assign cont1 = (second_byte & u8cw_pkg::MASK_CONT) == u8cw_pkg::CONT_PAT;
  assign cont2 = (third_byte  & u8cw_pkg::MASK_CONT) == u8cw_pkg::CONT_PAT;
  assign cont3 = (fourth_byte & u8cw_pkg::MASK_CONT) == u8cw_pkg::CONT_PAT;

  // Sequence decode; a malformed lead passes through as its own value.
  always_comb begin
    cp  = {13'd0, lead_byte};
    len = u8cw_pkg::LEN_1;
    ok  = 1'b0;
    if (!lead_byte[7]) begin
      ok = 1'b1;
    end else if ((lead_byte & u8cw_pkg::MASK_2B) == u8cw_pkg::LEAD_2B && cont1) begin
      cp  = {10'd0, lead_byte[4:0], second_byte[5:0]};
      len = u8cw_pkg::LEN_2;
      ok  = 1'b1;
    end else if ((lead_byte & u8cw_pkg::MASK_3B) == u8cw_pkg::LEAD_3B && cont1 && cont2) begin
      cp  = {5'd0, lead_byte[3:0], second_byte[5:0], third_byte[5:0]};
      len = u8cw_pkg::LEN_3;
      ok  = 1'b1;
    end else if ((lead_byte & u8cw_pkg::MASK_4B) == u8cw_pkg::LEAD_4B &&
                 cont1 && cont2 && cont3) begin
      cp  = {lead_byte[2:0], second_byte[5:0], third_byte[5:0], fourth_byte[5:0]};
      len = u8cw_pkg::LEN_4;
      ok  = 1'b1;
    end
  end

  // Width classes. All wide ranges sit in the basic multilingual plane.
  assign lo      = cp[15:0];
  assign bmp     = (cp[20:16] == 5'd0);
  assign is_ctrl = (cp < 21'h20) || (cp >= 21'h7F && cp < 21'hA0);
  assign is_wide = bmp && (
      (lo >= 16'h1100 && lo <= 16'h115F) || lo == 16'h2329 || lo == 16'h232A ||
      (lo >= 16'h2E80 && lo <= 16'hA4CF) || (lo >= 16'hAC00 && lo <= 16'hD7A3) ||
      (lo >= 16'hF900 && lo <= 16'hFAFF) || (lo >= 16'hFE10 && lo <= 16'hFE19) ||
      (lo >= 16'hFE30 && lo <= 16'hFE6F) || (lo >= 16'hFF00 && lo <= 16'hFF60) ||
      (lo >= 16'hFFE0 && lo <= 16'hFFE6));

  // Pack the result.
  always_comb begin
    result.code_point  = cp;
    result.seq_length  = len;
    result.well_formed = ok;
    if (is_ctrl) begin
      result.display_width = u8cw_pkg::WID_ZERO;
    end else if (is_wide) begin
      result.display_width = u8cw_pkg::WID_WIDE;
    end else begin
      result.display_width = u8cw_pkg::WID_NORMAL;
    end
  end

endmodule

### hw/rtl/utf8_codepoint_width_decoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_codepoint_width_decoder_unit
// Decodes one UTF-8 code point per item and reports its terminal width.
// Pipeline: an accepted item passes the input register, then the result
// register, before it is offered on the output.
// Throughput: one item per cycle while out_ready is high; each register stage
// advances when empty or taken, so a full output does not stall a free input.
// Reset: rst clears both stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module utf8_codepoint_width_decoder_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [u8cw_pkg::ByteW-1:0]         lead_byte,
  input  logic [u8cw_pkg::ByteW-1:0]         second_byte,
  input  logic [u8cw_pkg::ByteW-1:0]         third_byte,
  input  logic [u8cw_pkg::ByteW-1:0]         fourth_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [u8cw_pkg::CpW-1:0]           code_point,
  output logic [u8cw_pkg::LenW-1:0]          seq_length,
  output logic                               well_formed,
  output logic [u8cw_pkg::WidW-1:0]          display_width
);

  logic                        s1_valid;
  logic [u8cw_pkg::ByteW-1:0]  s1_b0;
  logic [u8cw_pkg::ByteW-1:0]  s1_b1;
  logic [u8cw_pkg::ByteW-1:0]  s1_b2;
  logic [u8cw_pkg::ByteW-1:0]  s1_b3;
  logic                        s1_ready;
  logic                        s2_valid;
  logic                        s2_ready;
  u8cw_pkg::result_t           s2_result;
  u8cw_pkg::result_t           dec_result;

  // Stage handshakes.
  assign s2_ready = !s2_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      s1_b0 <= lead_byte;
      s1_b1 <= second_byte;
      s1_b2 <= third_byte;
      s1_b3 <= fourth_byte;
    end
  end

  // Decode logic between the two registers.
  u8cw_decode u_decode (
    .lead_byte   (s1_b0),
    .second_byte (s1_b1),
    .third_byte  (s1_b2),
    .fourth_byte (s1_b3),
    .result      (dec_result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_ready) begin
      s2_result <= dec_result;
    end
  end

  // Output ports.
  assign out_valid     = s2_valid;
  assign code_point    = s2_result.code_point;
  assign seq_length    = s2_result.seq_length;
  assign well_formed   = s2_result.well_formed;
  assign display_width = s2_result.display_width;

  // A malformed item always consumes exactly its lead byte.
  a_malformed_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && !well_formed |-> seq_length == u8cw_pkg::LEN_1 &&
                                  code_point[20:8] == 13'd0)
    else $error("malformed item with bad length or code point");

  // Width code three is never produced.
  a_width_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> display_width != 2'd3)
    else $error("invalid display width code");

  // An accepted item occupies the input stage on the next cycle.
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s1_valid)
    else $error("accepted item lost from input stage");

  // A held input stage keeps its bytes while the result stage is blocked.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_ready |=> s1_valid && $stable(s1_b0) && $stable(s1_b1) &&
                              $stable(s1_b2) && $stable(s1_b3))
    else $error("input stage changed while stalled");

  // Every output item has a length from one to four.
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> seq_length != 3'd0 && seq_length <= u8cw_pkg::LEN_4)
    else $error("sequence length out of range");

endmodule

### verif/utf8_codepoint_width_decoder_unit_tb.sv
// ----------------------------------------------------------------------------
// utf8_codepoint_width_decoder_unit_tb
// Self-checking bench for the UTF-8 code point and width decoder. A short
// list of hand-picked byte windows comes first. Random windows follow, mostly
// well-formed sequences of every length, with width-boundary code points,
// overlong forms, broken continuations and raw noise mixed in. Each accepted
// item is decoded by a local predictor, and the results are compared in
// order. Sender gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module utf8_codepoint_width_decoder_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [u8cw_pkg::CpW-1:0] cp_t;

  localparam int unsigned HalfPeriod  = 6;
  localparam int unsigned ItemsPerRun = 215;
  localparam int unsigned CycleLimit  = 200000;

  // Hand-picked windows, lead byte in the top byte.
  localparam logic [31:0] DIRECTED_WINDOWS [23] = '{
    32'h00000000, 32'h7F000000, 32'h41FFFFFF, 32'hC2800000, 32'hC2A00000,
    32'hDFBF4100, 32'hC0800000, 32'hE1848000, 32'hE28CA900, 32'hE28CAA00,
    32'hEDA08000, 32'hEFBFBF00, 32'hF0908080, 32'hF7BFBFBF, 32'h80000000,
    32'hBF808080, 32'hF8808080, 32'hFFFFFFFF, 32'hC3000000, 32'hE3814100,
    32'hF09080C0, 32'hE0808000, 32'hEFBCA100
  };

  // Code points on both sides of every width boundary.
  localparam logic [20:0] WIDTH_EDGES [42] = '{
    21'h1F,   21'h20,   21'h7E,   21'h7F,   21'h9F,   21'hA0,   21'h10FF,
    21'h1100, 21'h115F, 21'h1160, 21'h2328, 21'h2329, 21'h232A, 21'h232B,
    21'h2E7F, 21'h2E80, 21'hA4CF, 21'hA4D0, 21'hABFF, 21'hAC00, 21'hD7A3,
    21'hD7A4, 21'hF8FF, 21'hF900, 21'hFAFF, 21'hFB00, 21'hFE0F, 21'hFE10,
    21'hFE19, 21'hFE1A, 21'hFE2F, 21'hFE30, 21'hFE6F, 21'hFE70, 21'hFEFF,
    21'hFF00, 21'hFF60, 21'hFF61, 21'hFFDF, 21'hFFE0, 21'hFFE6, 21'hFFE7
  };

  // Predicts the decode of each accepted window and checks results in order.
  class u8_decode_board;
    u8cw_pkg::result_t pending_results[$];
    int unsigned       errors;

    function new();
      errors = 0;
    endfunction

    function bit is_cont(logic [7:0] b);
      return (b & u8cw_pkg::MASK_CONT) == u8cw_pkg::CONT_PAT;
    endfunction

    function logic [u8cw_pkg::WidW-1:0] columns_of(logic [u8cw_pkg::CpW-1:0] cp);
      if (cp < 21'h20 || (cp >= 21'h7F && cp < 21'hA0)) return u8cw_pkg::WID_ZERO;
      if ((cp >= 21'h1100 && cp <= 21'h115F) || cp == 21'h2329 || cp == 21'h232A ||
          (cp >= 21'h2E80 && cp <= 21'hA4CF) || (cp >= 21'hAC00 && cp <= 21'hD7A3) ||
          (cp >= 21'hF900 && cp <= 21'hFAFF) || (cp >= 21'hFE10 && cp <= 21'hFE19) ||
          (cp >= 21'hFE30 && cp <= 21'hFE6F) || (cp >= 21'hFF00 && cp <= 21'hFF60) ||
          (cp >= 21'hFFE0 && cp <= 21'hFFE6))
        return u8cw_pkg::WID_WIDE;
      return u8cw_pkg::WID_NORMAL;
    endfunction

    function u8cw_pkg::result_t decode_window(logic [7:0] b0, logic [7:0] b1,
                                              logic [7:0] b2, logic [7:0] b3);
      u8cw_pkg::result_t r;
      // A malformed lead or broken continuation falls back to the lead byte.
      r.code_point  = {13'd0, b0};
      r.seq_length  = u8cw_pkg::LEN_1;
      r.well_formed = 1'b0;
      if (!b0[7]) begin
        r.well_formed = 1'b1;
      end else if ((b0 & u8cw_pkg::MASK_2B) == u8cw_pkg::LEAD_2B && is_cont(b1)) begin
        r.code_point  = {10'd0, b0[4:0], b1[5:0]};
        r.seq_length  = u8cw_pkg::LEN_2;
        r.well_formed = 1'b1;
      end else if ((b0 & u8cw_pkg::MASK_3B) == u8cw_pkg::LEAD_3B && is_cont(b1) &&
                   is_cont(b2)) begin
        r.code_point  = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
        r.seq_length  = u8cw_pkg::LEN_3;
        r.well_formed = 1'b1;
      end else if ((b0 & u8cw_pkg::MASK_4B) == u8cw_pkg::LEAD_4B && is_cont(b1) &&
                   is_cont(b2) && is_cont(b3)) begin
        r.code_point  = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
        r.seq_length  = u8cw_pkg::LEN_4;
        r.well_formed = 1'b1;
      end
      r.display_width = columns_of(r.code_point);
      return r;
    endfunction

    function void note_window(logic [7:0] b0, logic [7:0] b1,
                              logic [7:0] b2, logic [7:0] b3);
      pending_results.push_back(decode_window(b0, b1, b2, b3));
    endfunction

    function void check_decode(u8cw_pkg::result_t got);
      u8cw_pkg::result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result cp=%h len=%0d wf=%0d width=%0d", $time,
                 got.code_point, got.seq_length, got.well_formed, got.display_width);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.code_point !== want.code_point) begin
        $display("%0t: code_point mismatch: expected %h, got %h", $time,
                 want.code_point, got.code_point);
        errors++;
      end
      if (got.seq_length !== want.seq_length) begin
        $display("%0t: seq_length mismatch: expected %0d, got %0d", $time,
                 want.seq_length, got.seq_length);
        errors++;
      end
      if (got.well_formed !== want.well_formed) begin
        $display("%0t: well_formed mismatch: expected %0d, got %0d", $time,
                 want.well_formed, got.well_formed);
        errors++;
      end
      if (got.display_width !== want.display_width) begin
        $display("%0t: display_width mismatch: expected %0d, got %0d", $time,
                 want.display_width, got.display_width);
        errors++;
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_ready;
  logic [u8cw_pkg::ByteW-1:0]   lead_byte;
  logic [u8cw_pkg::ByteW-1:0]   second_byte;
  logic [u8cw_pkg::ByteW-1:0]   third_byte;
  logic [u8cw_pkg::ByteW-1:0]   fourth_byte;
  logic                         out_valid;
  logic                         out_ready;
  logic [u8cw_pkg::CpW-1:0]     code_point;
  logic [u8cw_pkg::LenW-1:0]    seq_length;
  logic                         well_formed;
  logic [u8cw_pkg::WidW-1:0]    display_width;

  u8_decode_board    board;
  int unsigned       idle_pct;
  int unsigned       stall_pct;
  int unsigned       cycle_count;

  utf8_codepoint_width_decoder_unit dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .lead_byte     (lead_byte),
    .second_byte   (second_byte),
    .third_byte    (third_byte),
    .fourth_byte   (fourth_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .code_point    (code_point),
    .seq_length    (seq_length),
    .well_formed   (well_formed),
    .display_width (display_width)
  );

  // Free-running clock.
  always begin
    #HalfPeriod clk = 1'b1;
    #HalfPeriod clk = 1'b0;
  end

  // Receiver stalls at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Handshakes are sampled mid-cycle, where every signal is settled; an item
  // seen here is taken at the following rising edge.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        board.note_window(lead_byte, second_byte, third_byte, fourth_byte);
      end
      if (out_valid && out_ready) begin
        board.check_decode(u8cw_pkg::result_t'{code_point, seq_length, well_formed,
                                               display_width});
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int unsigned min_length(logic [u8cw_pkg::CpW-1:0] cp);
    if (cp < 21'h80) return 1;
    if (cp < 21'h800) return 2;
    if (cp < 21'h10000) return 3;
    return 4;
  endfunction

  // Encodes a code point in the given length; bytes past the sequence are random.
  function automatic logic [31:0] encode_point(logic [u8cw_pkg::CpW-1:0] cp,
                                               int unsigned len);
    logic [31:0] w;
    w = $urandom();
    case (len)
      1: begin
        w[31:24] = {1'b0, cp[6:0]};
      end
      2: begin
        w[31:16] = {u8cw_pkg::LEAD_2B | {3'd0, cp[10:6]},
                    u8cw_pkg::CONT_PAT | {2'd0, cp[5:0]}};
      end
      3: begin
        w[31:8] = {u8cw_pkg::LEAD_3B | {4'd0, cp[15:12]},
                   u8cw_pkg::CONT_PAT | {2'd0, cp[11:6]},
                   u8cw_pkg::CONT_PAT | {2'd0, cp[5:0]}};
      end
      default: begin
        w = {u8cw_pkg::LEAD_4B | {5'd0, cp[20:18]},
             u8cw_pkg::CONT_PAT | {2'd0, cp[17:12]},
             u8cw_pkg::CONT_PAT | {2'd0, cp[11:6]},
             u8cw_pkg::CONT_PAT | {2'd0, cp[5:0]}};
      end
    endcase
    return w;
  endfunction

  // Mostly well-formed sequences, with overlong forms, broken sequences and noise.
  function automatic logic [31:0] random_window();
    logic [31:0]              w;
    logic [u8cw_pkg::CpW-1:0] cp;
    logic [7:0]               bad;
    int unsigned              pick;
    int unsigned              len;
    int unsigned              pos;
    pick = $urandom_range(99);
    if (pick < 12) begin
      w = encode_point(cp_t'($urandom_range(21'h7F)), 1);
    end else if (pick < 27) begin
      w = encode_point(cp_t'($urandom_range(21'h7FF, 21'h80)), 2);
    end else if (pick < 45) begin
      w = encode_point(cp_t'($urandom_range(21'hFFFF, 21'h800)), 3);
    end else if (pick < 57) begin
      w = encode_point(cp_t'($urandom_range(21'h1FFFFF, 21'h10000)), 4);
    end else if (pick < 75) begin
      cp = WIDTH_EDGES[$urandom_range(41)];
      w  = encode_point(cp, min_length(cp));
    end else if (pick < 80) begin
      // Small code point in a length of two to four bytes, often an overlong form.
      cp = cp_t'($urandom_range(21'h7FF));
      w  = encode_point(cp, $urandom_range(4, min_length(cp) < 2 ? 2 : min_length(cp)));
    end else if (pick < 90) begin
      // Valid lead with one continuation byte spoiled or cut off.
      len = $urandom_range(4, 2);
      w   = encode_point(cp_t'($urandom_range(21'h1FFFFF)), len);
      pos = $urandom_range(len - 1, 1);
      bad = 8'($urandom_range(255));
      if ((bad & u8cw_pkg::MASK_CONT) == u8cw_pkg::CONT_PAT) bad = bad ^ 8'h40;
      w[31 - 8 * pos -: 8] = bad;
    end else begin
      w = $urandom();
    end
    return w;
  endfunction

  // Called at a rising edge; returns at the edge where the item is taken.
  task automatic send_window(input logic [31:0] w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    lead_byte   <= w[31:24];
    second_byte <= w[23:16];
    third_byte  <= w[15:8];
    fourth_byte <= w[7:0];
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  // Holds the sender off until every pending result has been checked.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_results.size() != 0) @(posedge clk);
  endtask

  // Phase schedule: idle and stall percentages.
  initial begin
    int unsigned idle_plan[4];
    int unsigned stall_plan[4];
    idle_plan  = '{0, 47, 0, 25};
    stall_plan = '{0, 0, 47, 25};
    board       = new();
    cycle_count = 0;
    idle_pct    = 0;
    stall_pct   = 0;
    clk         = 1'b0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    out_ready   = 1'b0;
    lead_byte   = '0;
    second_byte = '0;
    third_byte  = '0;
    fourth_byte = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_WINDOWS[i]) send_window(DIRECTED_WINDOWS[i]);

    for (int p = 0; p < 4; p++) begin
      wait_drained();
      idle_pct  = idle_plan[p];
      stall_pct = stall_plan[p];
      repeat (ItemsPerRun) send_window(random_window());
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### utf8_codepoint_width_decoder_unit.f
hw/rtl/u8cw_pkg.sv
hw/rtl/u8cw_decode.sv
hw/rtl/utf8_codepoint_width_decoder_unit.sv
verif/utf8_codepoint_width_decoder_unit_tb.sv
